// File: rtl/gdd_pkg.sv
// Package for the group distance delta block: sizes, codes and the
// command/status structs between controller and datapath.
// No dependencies.
package gdd_pkg;

    // Sizes
    localparam int MAX_READS = 256;
    localparam int LBL_AW    = $clog2(MAX_READS);
    localparam int CNT_W     = $clog2(MAX_READS + 1);
    localparam int DIST_W    = 24;
    localparam int PAIR_W    = 15;
    localparam int SUM_W     = 40;
    localparam int DLT_W     = DIST_W + 1;
    localparam int CFG_AW    = 1;
    localparam int DIV_CW    = $clog2(SUM_W);

    localparam logic [PAIR_W-1:0] PAIR_MAX     = {PAIR_W{1'b1}};
    localparam logic [CNT_W-1:0]  MIN_READS_RST = CNT_W'(2);

    // Item functions
    localparam logic [1:0] FN_LABEL  = 2'd0;
    localparam logic [1:0] FN_ENTRY  = 2'd1;
    localparam logic [1:0] FN_FINISH = 2'd2;

    // Group labels
    localparam logic [1:0] LBL_A = 2'd0;
    localparam logic [1:0] LBL_B = 2'd1;

    // Result status codes
    localparam logic [1:0] RS_VALID     = 2'd0;
    localparam logic [1:0] RS_NO_READS  = 2'd1;
    localparam logic [1:0] RS_FEW_READS = 2'd2;
    localparam logic [1:0] RS_NO_PAIRS  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_READ_COUNT = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_MIN_READS  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic lbl_wr;     // store a label
        logic ent_take;   // distance entry accepted
        logic fin_start;  // finish accepted, reset the sweep
        logic sweep;      // label sweep running
        logic div_start;  // launch the divider
        logic div_sel_b;  // divider works on the between-group sum
        logic cap_w;      // capture within mean
        logic cap_b;      // capture between mean
        logic out_load;   // load the result register, clear sums
    } t_gdd_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sweep_done;
        logic div_done;
        logic out_free;
    } t_gdd_sts;

endpackage

// File: rtl/gdd_if.sv
// Valid/ready channel interfaces for input items, results and config writes.
// Depends on gdd_pkg for field widths.
interface gdd_in_if;
    import gdd_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [LBL_AW-1:0] row_index;
    logic [LBL_AW-1:0] col_index;
    logic [1:0]        label_code;
    logic [DIST_W-1:0] distance;
    logic              distance_missing;

    modport source (output valid, func, row_index, col_index, label_code, distance,
                    distance_missing, input ready);
    modport sink   (input valid, func, row_index, col_index, label_code, distance,
                    distance_missing, output ready);
endinterface

interface gdd_out_if;
    import gdd_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [CNT_W-1:0]  count_a;
    logic [CNT_W-1:0]  count_b;
    logic [PAIR_W-1:0] pairs_within;
    logic [PAIR_W-1:0] pairs_between;
    logic [DIST_W-1:0] mean_within;
    logic [DIST_W-1:0] mean_between;
    logic signed [DLT_W-1:0] delta;

    modport source (output valid, status, count_a, count_b, pairs_within, pairs_between,
                    mean_within, mean_between, delta, input ready);
    modport sink   (input valid, status, count_a, count_b, pairs_within, pairs_between,
                    mean_within, mean_between, delta, output ready);
endinterface

interface gdd_cfg_if;
    import gdd_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] index;
    logic [CNT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/gdd_ctrl.sv
// Controller state machine: input handshake, finish sequence
// (sweep, two divisions, result load). Depends on gdd_pkg.
module gdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_func,
    output logic              o_in_ready,
    input  gdd_pkg::t_gdd_sts i_sts,
    output gdd_pkg::t_gdd_cmd o_cmd
);
    import gdd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_DIVW  = 3'd2;
    localparam logic [2:0] S_DIVB  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_func)
                        FN_LABEL:  o_cmd.lbl_wr = 1'b1;
                        FN_ENTRY:  o_cmd.ent_take = 1'b1;
                        FN_FINISH: begin
                            o_cmd.fin_start = 1'b1;
                            n_state         = S_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVW;
                end
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_w     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_b = 1'b1;
                    n_state         = S_DIVB;
                end
            end
            S_DIVB: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_b = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/gdd_div.sv
// Restoring divider, one quotient bit per cycle, for the rounded means.
// Depends on gdd_pkg.
module gdd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [gdd_pkg::SUM_W-1:0]  i_dividend,
    input  logic [gdd_pkg::PAIR_W-1:0] i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [gdd_pkg::DIST_W-1:0] o_quotient
);
    import gdd_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [SUM_W-1:0]  r_quo;
    logic [PAIR_W-1:0] r_rem;
    logic [PAIR_W-1:0] r_dvs;

    logic [PAIR_W:0]   w_shift;
    logic              w_ge;
    logic [PAIR_W:0]   w_diff;
    logic [PAIR_W-1:0] n_rem;

    // One restoring step
    always_comb begin
        w_shift = {r_rem, r_quo[SUM_W-1]};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        w_diff  = w_shift - {1'b0, r_dvs};
        n_rem   = w_ge ? w_diff[PAIR_W-1:0] : w_shift[PAIR_W-1:0];
    end

    // Control: busy while the SUM_W quotient bits shift in, then a done beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient shifts into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo[DIST_W-1:0];

endmodule

// File: rtl/gdd_datapath.sv
// Datapath: config registers, label memory, pair accumulators, label sweep,
// shared divider and the result register. Depends on gdd_pkg and gdd_div.
module gdd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gdd_pkg::t_gdd_cmd i_cmd,
    output gdd_pkg::t_gdd_sts o_sts,
    // input payload
    input  logic [gdd_pkg::LBL_AW-1:0] i_row_index,
    input  logic [gdd_pkg::LBL_AW-1:0] i_col_index,
    input  logic [1:0]                 i_label_code,
    input  logic [gdd_pkg::DIST_W-1:0] i_distance,
    input  logic                       i_distance_missing,
    // config writes
    input  logic                       i_cfg_valid,
    input  logic [gdd_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [gdd_pkg::CNT_W-1:0]  i_cfg_data,
    // result channel
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [1:0]                 o_status,
    output logic [gdd_pkg::CNT_W-1:0]  o_count_a,
    output logic [gdd_pkg::CNT_W-1:0]  o_count_b,
    output logic [gdd_pkg::PAIR_W-1:0] o_pairs_within,
    output logic [gdd_pkg::PAIR_W-1:0] o_pairs_between,
    output logic [gdd_pkg::DIST_W-1:0] o_mean_within,
    output logic [gdd_pkg::DIST_W-1:0] o_mean_between,
    output logic signed [gdd_pkg::DLT_W-1:0] o_delta
);
    import gdd_pkg::*;

    // Config registers
    logic [CNT_W-1:0] r_read_count;
    logic [CNT_W-1:0] r_min_reads;
    logic [CNT_W-1:0] w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_count <= '0;
            r_min_reads  <= MIN_READS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_READ_COUNT: r_read_count <= i_cfg_data;
                CFG_MIN_READS:  r_min_reads  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the read count to the label store depth
    assign w_n = (r_read_count > CNT_W'(MAX_READS)) ? CNT_W'(MAX_READS) : r_read_count;

    // Label memory: one write port, two registered read ports
    logic [1:0]        r_label_mem [MAX_READS];
    logic [1:0]        r_lbl_a;
    logic [1:0]        r_lbl_b;
    logic [LBL_AW-1:0] w_addr_a;
    logic [CNT_W-1:0]  r_sweep_idx;

    assign w_addr_a = i_cmd.sweep ? r_sweep_idx[LBL_AW-1:0] : i_row_index;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lbl_wr) begin
            r_label_mem[i_row_index] <= i_label_code;
        end
        r_lbl_a <= r_label_mem[w_addr_a];
        r_lbl_b <= r_label_mem[i_col_index];
    end

    // Entry stage: check geometry and the missing flag now, labels arrive next cycle
    logic              r_ent_vld;
    logic [DIST_W-1:0] r_ent_dist;
    logic              w_ent_ok;

    assign w_ent_ok = i_cmd.ent_take && (i_row_index < i_col_index)
                      && (CNT_W'(i_col_index) < w_n) && !i_distance_missing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= 1'b0;
        end else begin
            r_ent_vld <= w_ent_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ent_ok) begin
            r_ent_dist <= i_distance;
        end
    end

    // Pair accumulators
    logic [SUM_W-1:0]  r_sum_w;
    logic [SUM_W-1:0]  r_sum_b;
    logic [PAIR_W-1:0] r_pw;
    logic [PAIR_W-1:0] r_pb;
    logic              w_lbl_ok;
    logic              w_same;

    assign w_lbl_ok = r_ent_vld && (r_lbl_a == LBL_A || r_lbl_a == LBL_B)
                      && (r_lbl_b == LBL_A || r_lbl_b == LBL_B);
    assign w_same   = (r_lbl_a == r_lbl_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_w <= '0;
            r_sum_b <= '0;
            r_pw    <= '0;
            r_pb    <= '0;
        end else if (i_cmd.out_load) begin
            r_sum_w <= '0;
            r_sum_b <= '0;
            r_pw    <= '0;
            r_pb    <= '0;
        end else if (w_lbl_ok) begin
            // drop the entry once its pair count saturates
            if (w_same) begin
                if (r_pw != PAIR_MAX) begin
                    r_sum_w <= r_sum_w + SUM_W'(r_ent_dist);
                    r_pw    <= r_pw + 1'b1;
                end
            end else if (r_pb != PAIR_MAX) begin
                r_sum_b <= r_sum_b + SUM_W'(r_ent_dist);
                r_pb    <= r_pb + 1'b1;
            end
        end
    end

    // Label sweep: read one entry a cycle, count its group in the cycle after
    logic             r_sweep_vld;
    logic [CNT_W-1:0] r_cnt_a;
    logic [CNT_W-1:0] r_cnt_b;
    logic             w_sweep_more;

    assign w_sweep_more = (r_sweep_idx < w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_idx <= '0;
            r_sweep_vld <= 1'b0;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
        end else if (i_cmd.fin_start) begin
            r_sweep_idx <= '0;
            r_sweep_vld <= 1'b0;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep_vld <= w_sweep_more;
            if (w_sweep_more) begin
                r_sweep_idx <= r_sweep_idx + 1'b1;
            end
            if (r_sweep_vld) begin
                if (r_lbl_a == LBL_A) begin
                    r_cnt_a <= r_cnt_a + 1'b1;
                end else if (r_lbl_a == LBL_B) begin
                    r_cnt_b <= r_cnt_b + 1'b1;
                end
            end
        end
    end

    // Shared divider: (sum + count/2) / count
    logic [SUM_W-1:0]  w_div_sum;
    logic [PAIR_W-1:0] w_div_cnt;
    logic [SUM_W-1:0]  w_dividend;
    logic              w_div_busy;
    logic              w_div_done;
    logic [DIST_W-1:0] w_quotient;

    assign w_div_sum  = i_cmd.div_sel_b ? r_sum_b : r_sum_w;
    assign w_div_cnt  = i_cmd.div_sel_b ? r_pb : r_pw;
    assign w_dividend = w_div_sum + SUM_W'(w_div_cnt >> 1);

    gdd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_div_cnt),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Capture means, zero for an empty count
    logic [DIST_W-1:0] r_mean_w;
    logic [DIST_W-1:0] r_mean_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_w) begin
            r_mean_w <= (r_pw == '0) ? '0 : w_quotient;
        end
        if (i_cmd.cap_b) begin
            r_mean_b <= (r_pb == '0) ? '0 : w_quotient;
        end
    end

    // Result status
    logic [1:0] w_status;
    logic       w_pairs_ok;

    always_comb begin
        if (w_n == '0) begin
            w_status = RS_NO_READS;
        end else if (r_cnt_a < r_min_reads || r_cnt_b < r_min_reads) begin
            w_status = RS_FEW_READS;
        end else if (r_pw == '0 || r_pb == '0) begin
            w_status = RS_NO_PAIRS;
        end else begin
            w_status = RS_VALID;
        end
        w_pairs_ok = (w_status == RS_VALID) || (w_status == RS_NO_PAIRS);
    end

    // Result register: holds until the beat is taken
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status        <= w_status;
            o_count_a       <= r_cnt_a;
            o_count_b       <= r_cnt_b;
            o_pairs_within  <= w_pairs_ok ? r_pw : '0;
            o_pairs_between <= w_pairs_ok ? r_pb : '0;
            o_mean_within   <= w_pairs_ok ? r_mean_w : '0;
            o_mean_between  <= w_pairs_ok ? r_mean_b : '0;
            o_delta         <= (w_status == RS_VALID)
                               ? DLT_W'({1'b0, r_mean_b}) - DLT_W'({1'b0, r_mean_w}) : '0;
        end
    end

    assign o_out_valid = r_out_vld;

    // Status to the controller
    assign o_sts.sweep_done = !r_sweep_vld && !w_sweep_more;
    assign o_sts.div_done   = w_div_done;
    assign o_sts.out_free   = !r_out_vld || i_out_ready;

`ifndef NO_ASSERTIONS
    // a new result never overwrites one still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("result loaded over a pending beat");

    // the shared divider is never restarted mid-division
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !w_div_busy)
        else $error("divider started while busy");

    // group counts never exceed the reads swept
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep && o_sts.sweep_done)
        |-> (({1'b0, r_cnt_a} + {1'b0, r_cnt_b}) <= {1'b0, w_n}))
        else $error("group counts exceed read count");
`endif

endmodule

// File: rtl/group_distance_delta_top.sv
// Label and distance items are accepted back to back while the controller is idle. A finish
// item sweeps the labels up to the clamped read count over the memory port, then runs one
// division per mean in the shared divider, then loads the result; items wait meanwhile.
// The result register holds a beat while new label and entry items are accepted.
// Reset (i_rst_n, synchronous, low) zeroes sums, counts and read count; labels stay.
module group_distance_delta_top (
    input logic       i_clk,
    input logic       i_rst_n,
    gdd_in_if.sink    i_in,
    gdd_out_if.source o_out,
    gdd_cfg_if.sink   i_cfg
);
    import gdd_pkg::*;

    t_gdd_cmd w_cmd;
    t_gdd_sts w_sts;
    logic     w_in_ready;

    // Config writes are always accepted
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    gdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_func     (i_in.func),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gdd_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_row_index        (i_in.row_index),
        .i_col_index        (i_in.col_index),
        .i_label_code       (i_in.label_code),
        .i_distance         (i_in.distance),
        .i_distance_missing (i_in.distance_missing),
        .i_cfg_valid        (i_cfg.valid),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_status           (o_out.status),
        .o_count_a          (o_out.count_a),
        .o_count_b          (o_out.count_b),
        .o_pairs_within     (o_out.pairs_within),
        .o_pairs_between    (o_out.pairs_between),
        .o_mean_within      (o_out.mean_within),
        .o_mean_between     (o_out.mean_between),
        .o_delta            (o_out.delta)
    );

endmodule

// File: bench/gdd_summary_check.sv
// Scoreboard for the group distance delta block: watches the item, result and
// register channels, keeps its own copy of labels, sums and registers, and
// compares every result beat with the oldest predicted summary. Uses gdd_pkg, gdd_if.
module gdd_summary_check (
    input  logic i_clk,
    input  logic i_rst_n,
    gdd_in_if    i_item,
    gdd_out_if   i_summary,
    gdd_cfg_if   i_reg,
    output int   o_fail_count,
    output int   o_pending
);
    import gdd_pkg::*;

    typedef struct packed {
        logic [1:0]        status;
        logic [CNT_W-1:0]  count_a;
        logic [CNT_W-1:0]  count_b;
        logic [PAIR_W-1:0] pairs_within;
        logic [PAIR_W-1:0] pairs_between;
        logic [DIST_W-1:0] mean_within;
        logic [DIST_W-1:0] mean_between;
        logic [DLT_W-1:0]  delta;
    } t_summary;

    t_summary          summary_q[$];
    logic [1:0]        label_mem [MAX_READS];
    logic [SUM_W-1:0]  within_sum;
    logic [SUM_W-1:0]  between_sum;
    logic [PAIR_W-1:0] within_pairs;
    logic [PAIR_W-1:0] between_pairs;
    logic [CNT_W-1:0]  reads_cfg;
    logic [CNT_W-1:0]  min_reads_cfg;
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : predict_summary
        t_summary          want;
        t_summary          seen;
        logic [CNT_W-1:0]  n_eff;
        logic [CNT_W-1:0]  tally_a;
        logic [CNT_W-1:0]  tally_b;
        logic [1:0]        lbl_r;
        logic [1:0]        lbl_c;
        logic [63:0]       mw;
        logic [63:0]       mb;
        if (!i_rst_n) begin
            summary_q.delete();
            for (int i = 0; i < MAX_READS; i++) label_mem[i] = LBL_A;
            within_sum    = '0;
            between_sum   = '0;
            within_pairs  = '0;
            between_pairs = '0;
            reads_cfg     = '0;
            min_reads_cfg = MIN_READS_RST;
        end else begin
            // Check a result beat against the oldest summary first
            if (i_summary.valid && i_summary.ready) begin
                if (summary_q.size() == 0) begin
                    report_mismatch("result beat with none pending", 64'd0, 64'd0);
                end else begin
                    want = summary_q.pop_front();
                    seen.status        = i_summary.status;
                    seen.count_a       = i_summary.count_a;
                    seen.count_b       = i_summary.count_b;
                    seen.pairs_within  = i_summary.pairs_within;
                    seen.pairs_between = i_summary.pairs_between;
                    seen.mean_within   = i_summary.mean_within;
                    seen.mean_between  = i_summary.mean_between;
                    seen.delta         = $unsigned(i_summary.delta);
                    if (seen.status !== want.status)
                        report_mismatch("status", seen.status, want.status);
                    if (seen.count_a !== want.count_a)
                        report_mismatch("count_a", seen.count_a, want.count_a);
                    if (seen.count_b !== want.count_b)
                        report_mismatch("count_b", seen.count_b, want.count_b);
                    if (seen.pairs_within !== want.pairs_within)
                        report_mismatch("pairs_within", seen.pairs_within, want.pairs_within);
                    if (seen.pairs_between !== want.pairs_between)
                        report_mismatch("pairs_between", seen.pairs_between,
                                        want.pairs_between);
                    if (seen.mean_within !== want.mean_within)
                        report_mismatch("mean_within", seen.mean_within, want.mean_within);
                    if (seen.mean_between !== want.mean_between)
                        report_mismatch("mean_between", seen.mean_between, want.mean_between);
                    if (seen.delta !== want.delta)
                        report_mismatch("delta", seen.delta, want.delta);
                end
            end

            // Track register writes
            if (i_reg.valid && i_reg.ready) begin
                if (i_reg.index == CFG_READ_COUNT) reads_cfg = i_reg.data;
                else if (i_reg.index == CFG_MIN_READS) min_reads_cfg = i_reg.data;
            end

            // Advance the model on every accepted item
            if (i_item.valid && i_item.ready) begin
                n_eff = (reads_cfg > CNT_W'(MAX_READS)) ? CNT_W'(MAX_READS) : reads_cfg;
                case (i_item.func)
                    FN_LABEL: begin
                        if (int'(i_item.row_index) < MAX_READS)
                            label_mem[i_item.row_index] = i_item.label_code;
                    end
                    FN_ENTRY: begin
                        // Upper triangle, in range and present only
                        if (i_item.row_index < i_item.col_index &&
                            CNT_W'(i_item.col_index) < n_eff && !i_item.distance_missing) begin
                            lbl_r = label_mem[i_item.row_index];
                            lbl_c = label_mem[i_item.col_index];
                            if ((lbl_r == LBL_A || lbl_r == LBL_B) &&
                                (lbl_c == LBL_A || lbl_c == LBL_B)) begin
                                // Drop entries once a pair count is saturated
                                if (lbl_r == lbl_c) begin
                                    if (within_pairs != PAIR_MAX) begin
                                        within_sum = within_sum + SUM_W'(i_item.distance);
                                        within_pairs++;
                                    end
                                end else if (between_pairs != PAIR_MAX) begin
                                    between_sum = between_sum + SUM_W'(i_item.distance);
                                    between_pairs++;
                                end
                            end
                        end
                    end
                    FN_FINISH: begin
                        tally_a = '0;
                        tally_b = '0;
                        for (int i = 0; i < MAX_READS; i++) begin
                            if (i < int'(n_eff)) begin
                                if (label_mem[i] == LBL_A) tally_a++;
                                else if (label_mem[i] == LBL_B) tally_b++;
                            end
                        end
                        want = '0;
                        if (n_eff == 0) begin
                            want.status = RS_NO_READS;
                        end else if (tally_a < min_reads_cfg || tally_b < min_reads_cfg) begin
                            want.status  = RS_FEW_READS;
                            want.count_a = tally_a;
                            want.count_b = tally_b;
                        end else begin
                            // Round to nearest, ties up; an empty mean is zero
                            mw = (within_pairs == 0) ? 64'd0 :
                                 (64'(within_sum) + 64'(within_pairs >> 1)) / 64'(within_pairs);
                            mb = (between_pairs == 0) ? 64'd0 :
                                 (64'(between_sum) + 64'(between_pairs >> 1)) /
                                 64'(between_pairs);
                            want.count_a       = tally_a;
                            want.count_b       = tally_b;
                            want.pairs_within  = within_pairs;
                            want.pairs_between = between_pairs;
                            want.mean_within   = DIST_W'(mw);
                            want.mean_between  = DIST_W'(mb);
                            if (within_pairs == 0 || between_pairs == 0) begin
                                want.status = RS_NO_PAIRS;
                            end else begin
                                want.status = RS_VALID;
                                want.delta  = DLT_W'(mb) - DLT_W'(mw);
                            end
                        end
                        summary_q = {summary_q, want};
                        // Every finish clears the sums, whatever the status
                        within_sum    = '0;
                        between_sum   = '0;
                        within_pairs  = '0;
                        between_pairs = '0;
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= summary_q.size();
    end

endmodule

// File: bench/tb_group_distance_delta_top.sv
// Top of the group distance delta bench: clock, reset, item and register
// stimulus, result back-pressure, watchdog and verdict.
// Uses gdd_pkg, gdd_if, gdd_summary_check and group_distance_delta_top.
module tb_group_distance_delta_top;
    import gdd_pkg::*;

    localparam logic [1:0] FN_SPARE  = 2'd3;
    localparam logic [1:0] LBL_OUT   = 2'd2;
    localparam logic [1:0] LBL_SPARE = 2'd3;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam int RANDOM_ITEMS = 490;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 6000;

    logic i_clk;
    logic i_rst_n;
    bit   hold_go = 1'b0;
    int   burst_left = 0;
    int   fail_total;
    int   pending;

    gdd_in_if  item_bus ();
    gdd_out_if summary_bus ();
    gdd_cfg_if reg_bus ();

    group_distance_delta_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_bus),
        .o_out   (summary_bus),
        .i_cfg   (reg_bus)
    );

    gdd_summary_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_bus),
        .i_summary    (summary_bus),
        .i_reg        (reg_bus),
        .o_fail_count (fail_total),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic [1:0] rand_label();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4) return LBL_A;
        if (p < 8) return LBL_B;
        if (p == 8) return LBL_OUT;
        return LBL_SPARE;
    endfunction

    // Mix extremes and small values into the distance
    function automatic logic [DIST_W-1:0] rand_distance();
        int p;
        p = $urandom_range(0, 7);
        if (p == 0) return '0;
        if (p == 1) return DIST_MAX;
        if (p == 2) return DIST_W'($urandom_range(0, 255));
        return DIST_W'($urandom);
    endfunction

    // Offer one item; bursts of random length with random gaps between them
    task automatic send_item(input logic [1:0] fn, input logic [7:0] row,
                             input logic [7:0] col, input logic [1:0] code,
                             input logic [DIST_W-1:0] dist_val, input logic miss);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                item_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item_bus.valid            <= 1'b1;
        item_bus.func             <= fn;
        item_bus.row_index        <= row;
        item_bus.col_index        <= col;
        item_bus.label_code       <= code;
        item_bus.distance         <= dist_val;
        item_bus.distance_missing <= miss;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
    endtask

    task automatic send_finish();
        send_item(FN_FINISH, 8'($urandom), 8'($urandom), 2'($urandom), DIST_W'($urandom),
                  1'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input int value);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data  <= CNT_W'(value);
        @(posedge i_clk);
        while (!reg_bus.ready) @(posedge i_clk);
        reg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait out all pending summaries and let entries drain
    task automatic settle();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Result side: stall pattern of its own plus one long hold-off
    initial begin : drain_results
        int mode;
        int mode_left;
        bit held;
        mode = 0;
        mode_left = 0;
        held = 1'b0;
        summary_bus.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_go && !held) begin
                held = 1'b1;
                summary_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: summary_bus.ready <= 1'b1;
                1: summary_bus.ready <= 1'($urandom_range(0, 1));
                default: summary_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // End the run when no channel moves a beat for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((item_bus.valid && item_bus.ready) || (summary_bus.valid && summary_bus.ready) ||
                (reg_bus.valid && reg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int useful;
        int phase;
        int finishes;
        int len;
        int pick;
        int rc;
        int mr;
        int n_eff;
        int col;
        int row;
        i_rst_n                   <= 1'b0;
        item_bus.valid            <= 1'b0;
        item_bus.func             <= FN_LABEL;
        item_bus.row_index        <= '0;
        item_bus.col_index        <= '0;
        item_bus.label_code       <= LBL_A;
        item_bus.distance         <= '0;
        item_bus.distance_missing <= 1'b0;
        reg_bus.valid             <= 1'b0;
        reg_bus.index             <= CFG_READ_COUNT;
        reg_bus.data              <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: no reads
        send_finish();

        // Preload every label so no unwritten entry is ever read
        for (int i = 0; i < MAX_READS; i++)
            send_item(FN_LABEL, 8'(i), 8'($urandom), rand_label(), DIST_W'($urandom), 1'b0);

        // Directed: a small matrix with every kind of entry
        settle();
        write_reg(CFG_READ_COUNT, 8);
        send_item(FN_LABEL, 8'd0, 8'd0, LBL_A, '0, 1'b0);
        send_item(FN_LABEL, 8'd1, 8'd0, LBL_A, '0, 1'b0);
        send_item(FN_LABEL, 8'd2, 8'd0, LBL_B, '0, 1'b0);
        send_item(FN_LABEL, 8'd3, 8'd0, LBL_B, '0, 1'b0);
        send_item(FN_LABEL, 8'd4, 8'd0, LBL_OUT, '0, 1'b0);
        send_item(FN_LABEL, 8'd5, 8'd0, LBL_SPARE, '0, 1'b0);
        send_item(FN_LABEL, 8'd6, 8'd0, LBL_A, '0, 1'b0);
        send_item(FN_LABEL, 8'd7, 8'd0, LBL_B, '0, 1'b0);
        send_item(FN_ENTRY, 8'd0, 8'd1, LBL_A, '0, 1'b0);
        send_item(FN_ENTRY, 8'd1, 8'd6, LBL_A, DIST_MAX, 1'b0);
        send_item(FN_ENTRY, 8'd0, 8'd2, LBL_A, DIST_MAX, 1'b0);
        send_item(FN_ENTRY, 8'd2, 8'd3, LBL_A, 24'd1, 1'b0);
        send_item(FN_ENTRY, 8'd1, 8'd3, LBL_A, 24'd1, 1'b0);
        send_item(FN_ENTRY, 8'd3, 8'd7, LBL_A, 24'h800000, 1'b0);
        send_item(FN_ENTRY, 8'd0, 8'd6, LBL_A, DIST_MAX, 1'b1);   // missing distance
        send_item(FN_ENTRY, 8'd3, 8'd3, LBL_A, DIST_MAX, 1'b0);   // diagonal
        send_item(FN_ENTRY, 8'd3, 8'd0, LBL_A, DIST_MAX, 1'b0);   // lower triangle
        send_item(FN_ENTRY, 8'd0, 8'd4, LBL_A, DIST_MAX, 1'b0);   // excluded read
        send_item(FN_ENTRY, 8'd5, 8'd6, LBL_A, DIST_MAX, 1'b0);   // label code three
        send_item(FN_ENTRY, 8'd0, 8'd8, LBL_A, DIST_MAX, 1'b0);   // column out of range
        send_item(FN_ENTRY, 8'd254, 8'd255, LBL_A, DIST_MAX, 1'b0);
        send_item(FN_SPARE, 8'd1, 8'd2, LBL_B, DIST_MAX, 1'b0);   // unknown func
        send_finish();
        send_finish();                                         // sums cleared: no pairs
        settle();
        write_reg(CFG_MIN_READS, 256);
        send_finish();                                         // too few per group
        settle();
        write_reg(CFG_READ_COUNT, 511);
        write_reg(CFG_MIN_READS, 0);
        send_finish();                                         // read count clamps

        // Random phases: mostly well-formed entries, some noise
        useful = 0;
        phase = 0;
        while (useful < RANDOM_ITEMS) begin
            settle();
            pick = $urandom_range(0, 99);
            if (pick < 40) rc = $urandom_range(2, 16);
            else if (pick < 60) rc = $urandom_range(17, 64);
            else if (pick < 75) rc = $urandom_range(65, 255);
            else if (pick < 85) rc = MAX_READS;
            else if (pick < 90) rc = $urandom_range(257, 511);
            else if (pick < 95) rc = 0;
            else rc = 1;
            pick = $urandom_range(0, 99);
            if (pick < 50) mr = $urandom_range(0, 3);
            else if (pick < 80) mr = 2;
            else if (pick < 90) mr = 256;
            else mr = $urandom_range(0, 511);
            finishes = $urandom_range(1, 2);
            // Hold results off while the sender keeps going
            if (phase == 2) begin
                rc = 6;
                mr = 0;
                finishes = 3;
            end
            write_reg(CFG_READ_COUNT, rc);
            write_reg(CFG_MIN_READS, mr);
            if (phase == 2) hold_go = 1'b1;
            n_eff = (rc > MAX_READS) ? MAX_READS : rc;
            repeat (finishes) begin
                len = $urandom_range(4, 40);
                repeat (len) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10) begin
                        send_item(FN_LABEL, 8'($urandom), 8'($urandom),
                                  ($urandom_range(0, 9) < 7) ? 2'($urandom_range(0, 1))
                                                             : 2'($urandom_range(2, 3)),
                                  DIST_W'($urandom), 1'($urandom));
                        useful++;
                    end else if (pick < 85 && n_eff >= 2) begin
                        col = $urandom_range(1, n_eff - 1);
                        row = $urandom_range(0, col - 1);
                        send_item(FN_ENTRY, 8'(row), 8'(col), 2'($urandom), rand_distance(),
                                  $urandom_range(0, 9) == 0);
                        useful++;
                    end else if (pick < 95) begin
                        send_item(FN_ENTRY, 8'($urandom), 8'($urandom), 2'($urandom),
                                  rand_distance(), 1'($urandom));
                    end else begin
                        send_item(FN_SPARE, 8'($urandom), 8'($urandom), 2'($urandom),
                                  DIST_W'($urandom), 1'($urandom));
                    end
                end
                send_finish();
                useful++;
            end
            phase++;
        end

        settle();
        repeat (100) @(posedge i_clk);
        if (fail_total == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: group_distance_delta_top.f
rtl/gdd_pkg.sv
rtl/gdd_if.sv
rtl/gdd_ctrl.sv
rtl/gdd_div.sv
rtl/gdd_datapath.sv
rtl/group_distance_delta_top.sv
bench/gdd_summary_check.sv
bench/tb_group_distance_delta_top.sv
